/* sv/mnslp_pkg.sv */
// ----------------------------------------------------------------------------
// mnslp_pkg: shared types and constants
// Field widths, event codes and the control bundle that the top level
// broadcasts to every cell of the key row.
// ----------------------------------------------------------------------------
`default_nettype none

package mnslp_pkg;

  localparam int KEY_W  = 7;
  localparam int VEL_W  = 7;
  localparam int HELD_W = 5;

  // event kind on the func input
  localparam logic FUNC_PRESS   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // broadcast from the top level to all cells
  typedef struct packed {
    logic             en;          // update pass, write data_next
    logic             is_release;  // 1: key release, 0: key press
    logic [KEY_W-1:0] key;         // key of the event
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/mnslp_cell.sv */
// ----------------------------------------------------------------------------
// mnslp_cell: one entry of the held-key row
// Holds one key, compares it with the event key, and on update either
// takes its upper neighbor (release shift), the event key (append), or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module mnslp_cell (
  input  wire logic                        clk,
  input  wire mnslp_pkg::cell_ctrl_t       ctrl,
  input  wire logic                        occ,        // this entry is held
  input  wire logic                        occ_below,  // entry below is held
  input  wire logic                        hit_below,  // match somewhere below
  input  wire logic                        found,      // match anywhere in row
  input  wire logic [mnslp_pkg::KEY_W-1:0] data_above,
  output logic                             hit_out,
  output logic      [mnslp_pkg::KEY_W-1:0] data,
  output logic      [mnslp_pkg::KEY_W-1:0] data_next
);

  logic match;
  logic append;

  always_comb begin
    match   = occ && (data == ctrl.key);
    hit_out = hit_below || match;
    // first free slot takes a new key on a press that is not already held
    append  = !ctrl.is_release && !found && !occ && occ_below;
    if (ctrl.is_release && hit_out) begin
      data_next = data_above;
    end else if (append) begin
      data_next = ctrl.key;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

/* sv/mono_note_stack_last_priority.sv */
// Result strobe (done) is registered at the end of the update pass (ST_EXEC).
// A new event is accepted only while idle; busy is high for the single update
//   cycle, in which the whole cell row compares, shifts or appends at once.
// Reset (rst, synchronous): held count and control cleared; stored keys are
//   not cleared and no clearing pass runs, so the block is ready right away.
// The receiver cannot stall: done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
// mono_note_stack_last_priority: monophonic last-note-priority key stack
// A row of STACK_DEPTH cells holds the pressed keys, oldest in cell 0.
// Press appends a key not yet held while a cell is free; release removes it,
// shifts the cells above down one place and replays the newest remaining key.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_note_stack_last_priority #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         func,
  input  wire logic [mnslp_pkg::KEY_W-1:0]  key,
  input  wire logic [mnslp_pkg::VEL_W-1:0]  velocity,
  output logic                              done,
  output logic                              gate,
  output logic      [mnslp_pkg::KEY_W-1:0]  play_key,
  output logic      [mnslp_pkg::VEL_W-1:0]  play_velocity,
  output logic      [mnslp_pkg::HELD_W-1:0] held
);

  localparam int D  = STACK_DEPTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // transfer captured at the accepting edge
  logic                        op_release;
  logic [mnslp_pkg::KEY_W-1:0] key_q;
  logic [mnslp_pkg::VEL_W-1:0] vel_q;

  // number of held keys; cell i is occupied when i < count
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  mnslp_pkg::cell_ctrl_t ctrl;

  logic [D-1:0] occ;
  logic [D-1:0] occ_next;
  logic [D-1:0] hit;
  logic [D-1:0] is_top;
  logic         found;

  logic [mnslp_pkg::KEY_W-1:0] data      [D];
  logic [mnslp_pkg::KEY_W-1:0] data_next [D];
  logic [mnslp_pkg::KEY_W-1:0] top_key;

  logic                         gate_next;
  logic [mnslp_pkg::KEY_W-1:0]  play_next;
  logic [CW+mnslp_pkg::HELD_W-1:0] held_wide;

  assign busy = (state == ST_EXEC);

  always_comb begin
    ctrl.en         = (state == ST_EXEC);
    ctrl.is_release = (op_release == mnslp_pkg::FUNC_RELEASE);
    ctrl.key        = key_q;
  end

  // the hit chain ripples up the row; its last tap says the key is held
  assign found = hit[D-1];

  // cell row
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                        occ_below_i;
    logic                        hit_below_i;
    logic [mnslp_pkg::KEY_W-1:0] data_above_i;

    assign occ[i]      = (CW'(i) < count);
    assign occ_next[i] = (CW'(i) < count_next);

    if (i == 0) begin : g_bottom
      assign occ_below_i = 1'b1;
      assign hit_below_i = 1'b0;
    end else begin : g_mid
      assign occ_below_i = occ[i-1];
      assign hit_below_i = hit[i-1];
    end

    if (i == D - 1) begin : g_top
      // top cell has no neighbor; after a shift it is unoccupied anyway
      assign data_above_i = data[i];
      assign is_top[i]    = occ_next[i];
    end else begin : g_low
      assign data_above_i = data[i+1];
      assign is_top[i]    = occ_next[i] && !occ_next[i+1];
    end

    mnslp_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .occ_below  (occ_below_i),
      .hit_below  (hit_below_i),
      .found      (found),
      .data_above (data_above_i),
      .hit_out    (hit[i]),
      .data       (data[i]),
      .data_next  (data_next[i])
    );
  end

  // newest key after the update: one-hot AND-OR over the row
  always_comb begin
    top_key = '0;
    for (int i = 0; i < D; i++) begin
      top_key = top_key | (data_next[i] & {mnslp_pkg::KEY_W{is_top[i]}});
    end
  end

  always_comb begin
    count_next = count;
    if (!ctrl.is_release && !found && (count != CW'(STACK_DEPTH))) begin
      count_next = count + CW'(1);
    end else if (ctrl.is_release && found) begin
      count_next = count - CW'(1);
    end
    // release leaving nothing held: voice off, report the released key
    if (ctrl.is_release && (count_next == '0)) begin
      gate_next = 1'b0;
      play_next = key_q;
    end else if (ctrl.is_release) begin
      gate_next = 1'b1;
      play_next = top_key;
    end else begin
      gate_next = 1'b1;
      play_next = key_q;
    end
    held_wide = {{mnslp_pkg::HELD_W{1'b0}}, count_next};
  end

  // control FSM and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          count <= count_next;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (state == ST_IDLE && start) begin
      op_release <= func;
      key_q      <= key;
      vel_q      <= velocity;
    end
    if (state == ST_EXEC) begin
      gate          <= gate_next;
      play_key      <= play_next;
      play_velocity <= vel_q;
      held          <= held_wide[mnslp_pkg::HELD_W-1:0];
    end
  end

  // an accepted transfer is answered by a done strobe after the update pass
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing after accepted transfer");

  // the update pass lasts exactly one cycle
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // held count never exceeds the row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  // voice off only when nothing is held
  a_gate_off_empty: assert property (@(posedge clk) disable iff (rst)
    (done && !gate) |-> (count == '0))
    else $error("note-off while keys still held");

  // a press always plays its own key
  a_press_plays_key: assert property (@(posedge clk) disable iff (rst)
    (busy && !ctrl.is_release) |=> (gate && (play_key == $past(key_q))))
    else $error("press did not play the pressed key");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: last-note-priority key stack check
// Drives press/release events through the start/busy command port and holds
// a model of the held-key stack to predict gate, key, velocity and held count.
// A monitor checks every done strobe against the oldest expected voice event.
// ----------------------------------------------------------------------------

module testbench;

  localparam int   KEY_W        = mnslp_pkg::KEY_W;
  localparam int   VEL_W        = mnslp_pkg::VEL_W;
  localparam int   HELD_W       = mnslp_pkg::HELD_W;
  localparam logic FUNC_PRESS   = mnslp_pkg::FUNC_PRESS;
  localparam logic FUNC_RELEASE = mnslp_pkg::FUNC_RELEASE;

  localparam int STACK_DEPTH = 16;
  localparam int MAX_GAP     = 12;
  // Roughly 900 events are sent; the watchdog sits well beyond the slowest
  // correct run.
  localparam int CYCLE_LIMIT = 200000;

  // One voice event as the block reports it.
  typedef struct packed {
    logic              gate;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  vel;
    logic [HELD_W-1:0] held;
  } voice_evt_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              func = FUNC_PRESS;
  logic [KEY_W-1:0]  key = '0;
  logic [VEL_W-1:0]  velocity = '0;
  logic              busy;
  logic              done;
  logic              gate;
  logic [KEY_W-1:0]  play_key;
  logic [VEL_W-1:0]  play_velocity;
  logic [HELD_W-1:0] held;

  // Model of the held keys: oldest in slot 0, newest at held_n-1.
  logic [KEY_W-1:0] held_keys [STACK_DEPTH];
  int               held_n = 0;

  voice_evt_t voice_q [$];    // voice events still owed by the block
  voice_evt_t want;
  int         err_cnt = 0;
  int         sent_cnt = 0;
  int         seen_cnt = 0;
  int         full_press_cnt = 0;
  int         empty_release_cnt = 0;
  int         cycle_cnt = 0;

  mono_note_stack_last_priority #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .key          (key),
    .velocity     (velocity),
    .done         (done),
    .gate         (gate),
    .play_key     (play_key),
    .play_velocity(play_velocity),
    .held         (held)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d voice events still pending",
               $time, voice_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Predict the voice event for one key event and advance the model.
  function automatic voice_evt_t voice_step(logic f, logic [KEY_W-1:0] k,
                                            logic [VEL_W-1:0] v);
    voice_evt_t r;
    int         pos;
    pos = held_n;
    for (int i = 0; i < held_n; i++)
      if (pos == held_n && held_keys[i] == k) pos = i;
    if (f == FUNC_PRESS) begin
      // new key goes on top; a held key or a full stack leaves it unchanged,
      // but the pressed key is played either way
      if (pos == held_n && held_n < STACK_DEPTH) begin
        held_keys[held_n] = k;
        held_n++;
      end
      r.gate = 1'b1;
      r.key  = k;
    end else begin
      if (pos < held_n) begin
        for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i + 1];
        held_n--;
      end
      // newest remaining key is replayed; empty stack releases the voice
      if (held_n > 0) begin
        r.gate = 1'b1;
        r.key  = held_keys[held_n - 1];
      end else begin
        r.gate = 1'b0;
        r.key  = k;
      end
    end
    r.vel  = v;
    r.held = HELD_W'(held_n);
    return r;
  endfunction

  // One command transfer. Start stays high after the transfer so that a
  // back-to-back event is driven in the same step without a low blip; any
  // caller that leaves the port idle calls port_idle().
  task automatic send_key_event(logic f, logic [KEY_W-1:0] k, logic [VEL_W-1:0] v);
    int gap;
    gap = $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 3) == 0) gap = 0;   // runs of back-to-back events
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    func     <= f;
    key      <= k;
    velocity <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer happened at the edge that raised busy: predict now, before any later event
    if (f == FUNC_PRESS && held_n == STACK_DEPTH) full_press_cnt++;
    if (f == FUNC_RELEASE && held_n == 0) empty_release_cnt++;
    voice_q.push_back(voice_step(f, k, v));
    sent_cnt++;
  endtask

  task automatic port_idle();
    start <= 1'b0;
  endtask

  // Sender holds off until the block has answered everything.
  task automatic wait_all_voiced();
    port_idle();
    while (voice_q.size() != 0) @(posedge clk);
  endtask

  // Result monitor: done is a one-cycle strobe, sampled at the edge ending it.
  always @(posedge clk) begin
    if (!rst && done) begin
      seen_cnt++;
      if (voice_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result gate=%0d key=%0d vel=%0d held=%0d",
                 $time, gate, play_key, play_velocity, held);
      end else begin
        want = voice_q.pop_front();
        if (gate !== want.gate) begin
          err_cnt++;
          $display("%0t: gate expected %0d actual %0d", $time, want.gate, gate);
        end
        if (play_key !== want.key) begin
          err_cnt++;
          $display("%0t: play_key expected %0d actual %0d", $time, want.key, play_key);
        end
        if (play_velocity !== want.vel) begin
          err_cnt++;
          $display("%0t: play_velocity expected %0d actual %0d",
                   $time, want.vel, play_velocity);
        end
        if (held !== want.held) begin
          err_cnt++;
          $display("%0t: held expected %0d actual %0d", $time, want.held, held);
        end
      end
    end
  end

  // Field extremes and each corner of the stack: empty release, repeat
  // press, stray release, top release, full stack, middle removal.
  task automatic test_directed_cases();
    send_key_event(FUNC_RELEASE, 7'd5, 7'd127);    // empty stack -> note-off
    send_key_event(FUNC_PRESS, 7'd0, 7'd0);
    send_key_event(FUNC_PRESS, 7'd127, 7'd127);
    send_key_event(FUNC_PRESS, 7'd0, 7'd64);       // already held
    send_key_event(FUNC_RELEASE, 7'd99, 7'd1);     // not held, stack not empty
    send_key_event(FUNC_RELEASE, 7'd127, 7'd126);  // top gone, retrigger 0
    send_key_event(FUNC_RELEASE, 7'd0, 7'd0);      // last key -> note-off
    for (int i = 0; i < STACK_DEPTH; i++)
      send_key_event(FUNC_PRESS, KEY_W'(10 + i), VEL_W'(8 * i));
    send_key_event(FUNC_PRESS, 7'd126, 7'd85);     // stack full, still plays
    send_key_event(FUNC_RELEASE, 7'd17, 7'd42);    // middle key, upper shift down
    wait_all_voiced();
  endtask

  // Realistic playing: presses and releases of held keys over a moving
  // 20-key window, with some releases of keys that are not down.
  task automatic test_chord_play(int n_events);
    int base;
    int pick;
    base = $urandom_range(0, 107);
    for (int n = 0; n < n_events; n++) begin
      if (n % 40 == 39) base = $urandom_range(0, 107);
      pick = $urandom_range(0, 99);
      if (held_n == 0 || pick < 50)
        send_key_event(FUNC_PRESS, KEY_W'(base + $urandom_range(0, 19)),
                       VEL_W'($urandom_range(0, 127)));
      else if (pick < 90)
        send_key_event(FUNC_RELEASE, held_keys[$urandom_range(0, held_n - 1)],
                       VEL_W'($urandom_range(0, 127)));
      else
        send_key_event(FUNC_RELEASE, KEY_W'(base + $urandom_range(0, 19)),
                       VEL_W'($urandom_range(0, 127)));
    end
    port_idle();
  endtask

  // Press 20 distinct keys in shuffled order (the last four overflow a full
  // stack), then release everything in random order, then pause for results.
  task automatic test_fill_and_flush(int n_rounds);
    logic [KEY_W-1:0] run_keys [20];
    logic [KEY_W-1:0] tmp;
    int               base;
    int               j;
    for (int r = 0; r < n_rounds; r++) begin
      // start every round from an empty stack
      while (held_n > 0)
        send_key_event(FUNC_RELEASE, held_keys[held_n - 1], VEL_W'($urandom_range(0, 127)));
      base = (r == 0) ? 107 : $urandom_range(0, 107);
      for (int i = 0; i < 20; i++) run_keys[i] = KEY_W'(base + i);
      for (int i = 19; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = run_keys[i];
        run_keys[i] = run_keys[j];
        run_keys[j] = tmp;
      end
      for (int i = 0; i < 20; i++)
        send_key_event(FUNC_PRESS, run_keys[i], VEL_W'($urandom_range(0, 127)));
      // a repeat press while full
      send_key_event(FUNC_PRESS, run_keys[$urandom_range(0, 15)],
                     VEL_W'($urandom_range(0, 127)));
      // the overflow keys were never stored; releasing them only retriggers
      for (int i = 16; i < 20; i += 2)
        send_key_event(FUNC_RELEASE, run_keys[i], VEL_W'($urandom_range(0, 127)));
      while (held_n > 0)
        send_key_event(FUNC_RELEASE, held_keys[$urandom_range(0, held_n - 1)],
                       VEL_W'($urandom_range(0, 127)));
      wait_all_voiced();
    end
  endtask

  // Unstructured events over the whole key and velocity range.
  task automatic test_random_events(int n_events);
    for (int n = 0; n < n_events; n++)
      send_key_event(logic'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 127)),
                     VEL_W'($urandom_range(0, 127)));
    port_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_chord_play(350);
    test_fill_and_flush(6);
    test_random_events(150);
    test_chord_play(100);

    // everything sent; let the last results come out, then leave the port quiet
    wait_all_voiced();
    repeat (6) @(posedge clk);

    $display("Sent %0d key events, checked %0d voice events", sent_cnt, seen_cnt);
    $display("Presses on a full stack: %0d, releases on an empty stack: %0d",
             full_press_cnt, empty_release_cnt);
    if (err_cnt == 0 && voice_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d voice events never seen", err_cnt, voice_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
